[src/sha1_pkg.sv]
// Shared types, constants and control structs of the SHA-1 hash engine.
`default_nettype none
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumCv   = 5;
  localparam int unsigned NumWin  = 16;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned RndW    = $clog2(NumRnd);
  localparam int unsigned PosW    = $clog2(NumWin);
  localparam int unsigned OutIdxW = 3;

  typedef logic [WordW-1:0]         word_t;
  typedef logic [NumCv-1:0][WordW-1:0] cv_t;
  typedef logic [RndW-1:0]          rnd_t;

  // Index 0 is the most significant chaining word (A / H0).
  localparam cv_t InitCv = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                            32'hefcdab89, 32'h67452301};

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam word_t PadMarker = 32'h80000000;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_FINAL = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  put;
    logic  expand;
  } sched_ctrl_t;

  typedef struct packed {
    logic  load;
    logic  step;
    rnd_t  rnd;
  } core_ctrl_t;

endpackage
`default_nettype wire

[src/sha1_sched.sv]
// Message schedule: sixteen-word shift line holding the block and its expansion.
`default_nettype none
module sha1_sched (
  input  wire logic                  clk_i,
  input  wire sha1_pkg::sched_ctrl_t ctrl_i,
  input  wire sha1_pkg::word_t       put_word_i,
  output sha1_pkg::word_t            w_o
);
  import sha1_pkg::*;

  word_t win_q [NumWin];
  word_t win_d [NumWin];
  word_t expand;

  // The line holds W[t] .. W[t+15]; the new word is W[t+16].
  assign expand = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_o    = win_q[0];

  always_comb begin
    for (int i = 0; i < NumWin - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[NumWin-1] = ctrl_i.expand ? {expand[WordW-2:0], expand[WordW-1]} : put_word_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.put || ctrl_i.expand) begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

[src/sha1_core.sv]
// Working variables A to E and the shared SHA-1 round unit.
`default_nettype none
module sha1_core (
  input  wire logic                 clk_i,
  input  wire sha1_pkg::core_ctrl_t ctrl_i,
  input  wire sha1_pkg::cv_t        cv_i,
  input  wire sha1_pkg::word_t      w_i,
  output sha1_pkg::cv_t             work_o
);
  import sha1_pkg::*;

  cv_t   work_q;
  cv_t   work_d;
  word_t f;
  word_t k;
  word_t b;
  word_t c;
  word_t d;

  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];

  // Round function and constant change every twenty rounds.
  always_comb begin
    priority if (ctrl_i.rnd < RndW'(20)) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctrl_i.rnd < RndW'(40)) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctrl_i.rnd < RndW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = cv_i;
    end else if (ctrl_i.step) begin
      work_d[0] = {work_q[0][WordW-6:0], work_q[0][WordW-1:WordW-5]} + f + work_q[4]
                  + w_i + k;
      work_d[1] = work_q[0];
      work_d[2] = {b[1:0], b[WordW-1:2]};
      work_d[3] = c;
      work_d[4] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work_o = work_q;

endmodule
`default_nettype wire

[src/sha1_hash_engine.sv]
// Top level of the SHA-1 hash engine: sequencer, chaining words, length and digest output.
`default_nettype none
// Usage.
// An input beat is taken at a rising edge where start_i is high and busy_o is
// low. action_i selects a start (reload the initial chaining values and clear
// the length), a full big-endian message word, or a final word carrying
// valid_bytes_i leading bytes. Action code 3 is taken and ignored.
// A full word is absorbed while the engine stays idle. The sixteenth word of
// a block starts the compression: 80 rounds, one per cycle through a single
// shared round unit, then an update step adding into the chaining words.
// busy_o stays high through the rounds and the update; no beat is taken then.
// A final beat appends the padding and the 64-bit length one word per cycle
// while no compression runs, runs one or two more compressions and then
// presents the five digest words on consecutive cycles, most significant
// first, each marked by digest_valid_o high, with last_o on the fifth; the
// receiver cannot stall them. The second compression runs when fewer than
// two words were free for the length after the final word. The engine then
// returns to idle with the initial chaining values and a cleared position
// and length.
// Reset (rst_ni low, asynchronous) loads the initial chaining values and
// clears the block position and the length.
module sha1_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] word_i,
  input  wire logic [1:0]  valid_bytes_i,
  output logic             digest_valid_o,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_o
);
  import sha1_pkg::*;

  state_e                 state_q, state_d;
  logic   [PosW-1:0]      pos_q, pos_d;
  logic   [63:0]          count_q, count_d;
  cv_t                    cv_q, cv_d;
  logic                   pad_q, pad_d;       // finishing a message
  logic                   lenhi_q, lenhi_d;   // upper length word is in
  logic                   done_q, done_d;     // lower length word is in
  rnd_t                   rnd_q, rnd_d;
  logic   [OutIdxW-1:0]   oidx_q, oidx_d;

  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;
  word_t       put_data;
  word_t       w;
  cv_t         work;
  logic        put;

  // Keep the valid leading bytes and place the 0x80 marker right after them.
  function automatic word_t pad_last(word_t data, logic [1:0] vb);
    word_t keep;
    keep = (vb == 2'd0) ? '0 : ~({WordW{1'b1}} >> {vb, 3'b000});
    return (data & keep) | (PadMarker >> {vb, 3'b000});
  endfunction

  sha1_sched u_sched (
    .clk_i      (clk_i),
    .ctrl_i     (sched_ctrl),
    .put_word_i (put_data),
    .w_o        (w)
  );

  sha1_core u_core (
    .clk_i  (clk_i),
    .ctrl_i (core_ctrl),
    .cv_i   (cv_q),
    .w_i    (w),
    .work_o (work)
  );

  always_comb begin
    state_d         = state_q;
    pos_d           = pos_q;
    count_d         = count_q;
    cv_d            = cv_q;
    pad_d           = pad_q;
    lenhi_d         = lenhi_q;
    done_d          = done_q;
    rnd_d           = rnd_q;
    oidx_d          = oidx_q;
    put             = 1'b0;
    put_data        = '0;
    sched_ctrl      = '0;
    core_ctrl       = '0;
    core_ctrl.rnd   = rnd_q;
    digest_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (action_e'(action_i))
            ACT_START: begin
              cv_d    = InitCv;
              pos_d   = '0;
              count_d = '0;
            end
            ACT_WORD: begin
              count_d  = count_q + 64'd32;
              put      = 1'b1;
              put_data = word_i;
            end
            ACT_FINAL: begin
              count_d  = count_q + {59'd0, valid_bytes_i, 3'b000};
              put      = 1'b1;
              put_data = pad_last(word_i, valid_bytes_i);
              pad_d    = 1'b1;
              state_d  = ST_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAD: begin
        // Zeros up to word 14, then the two length words; a block that has
        // only word 15 free is flushed with a zero first.
        put = 1'b1;
        if (pos_q == PosW'(14) && !lenhi_q) begin
          put_data = count_q[63:32];
          lenhi_d  = 1'b1;
        end else if (pos_q == PosW'(15) && lenhi_q) begin
          put_data = count_q[31:0];
          done_d   = 1'b1;
        end
      end
      ST_ROUND: begin
        core_ctrl.step    = 1'b1;
        sched_ctrl.expand = 1'b1;
        rnd_d             = rnd_q + RndW'(1);
        if (rnd_q == RndW'(NumRnd - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < NumCv; i++) begin
          cv_d[i] = cv_q[i] + work[i];
        end
        priority if (done_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        digest_valid_o = 1'b1;
        oidx_d         = oidx_q + OutIdxW'(1);
        if (oidx_q == OutIdxW'(NumCv - 1)) begin
          state_d = ST_IDLE;
          oidx_d  = '0;
          cv_d    = InitCv;
          pos_d   = '0;
          count_d = '0;
          pad_d   = 1'b0;
          lenhi_d = 1'b0;
          done_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Every word entering the block advances the position; the sixteenth
    // starts a compression from the current chaining words.
    if (put) begin
      sched_ctrl.put = 1'b1;
      pos_d          = pos_q + PosW'(1);
      if (pos_q == PosW'(NumWin - 1)) begin
        core_ctrl.load = 1'b1;
        rnd_d          = '0;
        state_d        = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      cv_q    <= InitCv;
      pad_q   <= 1'b0;
      lenhi_q <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      cv_q    <= cv_d;
      pad_q   <= pad_d;
      lenhi_q <= lenhi_d;
      done_q  <= done_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign digest_word_o = cv_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_o        = digest_valid_o && (oidx_q == OutIdxW'(NumCv - 1));

endmodule
`default_nettype wire
